### rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define BTHA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check.
`define BTHA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/btha_pkg.sv
// Types and constants of the boundary-tag heap allocator.
`timescale 1ns / 1ps
package btha_pkg;

   localparam int ADDR_W    = 34;
   localparam int GRANULE_BYTES = 16;
   localparam int HDR_BYTES = 16;
   localparam int FTR_BYTES = 8;
   localparam int MIN_BLOCK = 48;

   localparam logic [1:0] CMD_FORMAT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC   = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FMT   = 3'd1;
   localparam logic [2:0] ST_BAD_ALIGN = 3'd2;
   localparam logic [2:0] ST_NO_FIT    = 3'd3;
   localparam logic [2:0] ST_IGNORED   = 3'd4;
   localparam logic [2:0] ST_TOO_SMALL = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [16:0] request_bytes;
      logic [16:0] align_bytes;
      logic [31:0] release_addr;
   } req_type;

   typedef struct packed {
      logic [31:0] payload_addr;
      logic [2:0]  status;
      logic [16:0] free_total;
      logic [16:0] heap_total;
   } rsp_type;

   typedef enum logic [5:0] {
      OP_NONE, OP_LATCH, OP_DISPATCH, OP_FMT_NXT, OP_FMT_PRV,
      OP_A_LOOP, OP_A_HDR, OP_A_BUMP, OP_A_FIT, OP_A_NEXT, OP_A_PFX,
      OP_A_PPUSH, OP_A_USED, OP_A_SUF, OP_A_SPUSH,
      OP_R_WALK, OP_R_WHDR, OP_R_FOUND, OP_R_NX, OP_R_NXH, OP_R_NXM,
      OP_R_PV, OP_R_PVF, OP_R_PVH, OP_R_PVM, OP_R_PUSH,
      OP_T0, OP_T1, OP_P0, OP_P1, OP_P2,
      OP_U0, OP_U1, OP_U2, OP_U3, OP_U4, OP_U5, OP_EMIT
   } op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       disp_ok;
      logic       out_free;
      logic       node_zero;
      logic       bump;
      logic       fits;
      logic       pfx_big;
      logic       suf_big;
      logic       suf_nz;
      logic       h_end;
      logic       found;
      logic       s_zero;
      logic       nx_in;
      logic       rd_used;
      logic       h_gt;
      logic       pv_ge;
   } flags_type;

endpackage

### rtl/core/boundary_tag_heap_allocator.sv
// Top level of the boundary-tag heap allocator: register port and core.
// Usage:
//   Commands arrive as beats on the req_ channel (format, allocate, release)
//   and each produces exactly one result beat on the rsp_ channel with the
//   granted address, a status code and the free and heap byte totals.
//   The user sets the region base and length through the csr_ port while idle;
//   the block does not enforce it. Format lays the region out as a single free block.
//   One command is worked at a time. The heap memory has one port, so each
//   step makes at most one memory access per cycle:
//     format    writes the tags and list links of the single free block;
//     allocate  visits free blocks (with alignment bumps), then unlinks,
//               splits and pushes the leftover pieces onto the list;
//     release   walks heap blocks to find the grant, then merges with
//               free neighbors and pushes the result onto the list.
//   req_stall is low only while no command is being worked. The result sits
//   in an output register, so a new command is taken while it waits; a
//   stalled rsp_ beat holds, and the sequencer waits before writing the next.
//   Reset leaves the heap unformatted with zero totals; no memory clearing
//   pass is needed because the heap is rebuilt by format.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module boundary_tag_heap_allocator #(
   parameter int HEAP_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  btha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output btha_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import btha_pkg::*;

   logic [31:0] region_start_ff, region_start_in;
   logic [16:0] region_bytes_ff, region_bytes_in;
   logic        csr_wr;

   flags_type flags;
   op_type    op;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      region_start_in = region_start_ff;
      region_bytes_in = region_bytes_ff;
      if (csr_wr) begin
         if (csr_paddr[2]) region_bytes_in = csr_pwdata[16:0];
         else              region_start_in = csr_pwdata;
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'(region_bytes_ff) : region_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_bytes_ff <= '0;
      end else begin
         region_start_ff <= region_start_in;
         region_bytes_ff <= region_bytes_in;
      end
   end

   btha_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .op        (op)
   );

   btha_dp #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .req_data     (req_data),
      .region_start (region_start_ff),
      .region_bytes (region_bytes_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .flags        (flags)
   );

   `BTHA_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block took a beat without going busy")
   `BTHA_ASSERT_IMP(a_grant_only_ok, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.payload_addr == '0, "address granted on a failed command")
   `BTHA_ASSERT_IMP(a_grant_granule, clock, reset, rsp_valid, rsp_data.payload_addr[3:0] == 4'd0, "granted address off the granule grid")

endmodule

### rtl/core/btha_ctl.sv
// Sequencer of the allocator: walks each command through its steps.
`timescale 1ns / 1ps
module btha_ctl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  btha_pkg::flags_type flags,
   output btha_pkg::op_type    op
);
   import btha_pkg::*;

   localparam int NS = 37;

   typedef enum logic [NS-1:0] {
      S_IDLE     = (NS'(1) << 0),
      S_DISPATCH = (NS'(1) << 1),
      S_FMT_NXT  = (NS'(1) << 2),
      S_FMT_PRV  = (NS'(1) << 3),
      S_A_LOOP   = (NS'(1) << 4),
      S_A_HDR    = (NS'(1) << 5),
      S_A_BUMP   = (NS'(1) << 6),
      S_A_FIT    = (NS'(1) << 7),
      S_A_NEXT   = (NS'(1) << 8),
      S_A_PFX    = (NS'(1) << 9),
      S_A_PPUSH  = (NS'(1) << 10),
      S_A_USED   = (NS'(1) << 11),
      S_A_SUF    = (NS'(1) << 12),
      S_A_SPUSH  = (NS'(1) << 13),
      S_R_WALK   = (NS'(1) << 14),
      S_R_WHDR   = (NS'(1) << 15),
      S_R_FOUND  = (NS'(1) << 16),
      S_R_NX     = (NS'(1) << 17),
      S_R_NXH    = (NS'(1) << 18),
      S_R_NXM    = (NS'(1) << 19),
      S_R_PV     = (NS'(1) << 20),
      S_R_PVF    = (NS'(1) << 21),
      S_R_PVH    = (NS'(1) << 22),
      S_R_PVM    = (NS'(1) << 23),
      S_R_PUSH   = (NS'(1) << 24),
      S_T0       = (NS'(1) << 25),
      S_T1       = (NS'(1) << 26),
      S_P0       = (NS'(1) << 27),
      S_P1       = (NS'(1) << 28),
      S_P2       = (NS'(1) << 29),
      S_U0       = (NS'(1) << 30),
      S_U1       = (NS'(1) << 31),
      S_U2       = (NS'(1) << 32),
      S_U3       = (NS'(1) << 33),
      S_U4       = (NS'(1) << 34),
      S_U5       = (NS'(1) << 35),
      S_DONE     = (NS'(1) << 36)
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            op = OP_DISPATCH;
            if (!flags.disp_ok) begin
               state_in = S_DONE;
            end else begin
               unique case (flags.cmd)
                  CMD_FORMAT: begin
                     state_in = S_T0;
                     ret_in   = S_FMT_NXT;
                  end
                  CMD_ALLOC:   state_in = S_A_LOOP;
                  CMD_RELEASE: state_in = S_R_WALK;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_FMT_NXT: begin
            op       = OP_FMT_NXT;
            state_in = S_FMT_PRV;
         end
         S_FMT_PRV: begin
            op       = OP_FMT_PRV;
            state_in = S_DONE;
         end
         S_A_LOOP: begin
            op       = OP_A_LOOP;
            state_in = flags.node_zero ? S_DONE : S_A_HDR;
         end
         S_A_HDR: begin
            op       = OP_A_HDR;
            state_in = S_A_BUMP;
         end
         S_A_BUMP: begin
            op       = OP_A_BUMP;
            state_in = flags.bump ? S_A_BUMP : S_A_FIT;
         end
         S_A_FIT: begin
            op = OP_A_FIT;
            if (flags.fits) begin
               state_in = S_U0;
               ret_in   = S_A_PFX;
            end else begin
               state_in = S_A_NEXT;
            end
         end
         S_A_NEXT: begin
            op       = OP_A_NEXT;
            state_in = S_A_LOOP;
         end
         S_A_PFX: begin
            op = OP_A_PFX;
            if (flags.pfx_big) begin
               state_in = S_T0;
               ret_in   = S_A_PPUSH;
            end else begin
               state_in = S_A_USED;
            end
         end
         S_A_PPUSH: begin
            op       = OP_A_PPUSH;
            state_in = S_P0;
            ret_in   = S_A_USED;
         end
         S_A_USED: begin
            op       = OP_A_USED;
            state_in = S_T0;
            ret_in   = S_A_SUF;
         end
         S_A_SUF: begin
            op = OP_A_SUF;
            priority if (flags.suf_big) begin
               state_in = S_T0;
               ret_in   = S_A_SPUSH;
            end else if (flags.suf_nz) begin
               state_in = S_T0;
               ret_in   = S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_A_SPUSH: begin
            op       = OP_A_SPUSH;
            state_in = S_P0;
            ret_in   = S_DONE;
         end
         S_R_WALK: begin
            op       = OP_R_WALK;
            state_in = flags.h_end ? S_DONE : S_R_WHDR;
         end
         S_R_WHDR: begin
            op = OP_R_WHDR;
            priority if (flags.found) state_in = S_R_FOUND;
            else if (flags.s_zero)    state_in = S_DONE;
            else                      state_in = S_R_WALK;
         end
         S_R_FOUND: begin
            op       = OP_R_FOUND;
            state_in = S_T0;
            ret_in   = S_R_NX;
         end
         S_R_NX: begin
            op       = OP_R_NX;
            state_in = flags.nx_in ? S_R_NXH : S_R_PV;
         end
         S_R_NXH: begin
            op = OP_R_NXH;
            if (!flags.rd_used) begin
               state_in = S_U0;
               ret_in   = S_R_NXM;
            end else begin
               state_in = S_R_PV;
            end
         end
         S_R_NXM: begin
            op       = OP_R_NXM;
            state_in = S_T0;
            ret_in   = S_R_PV;
         end
         S_R_PV: begin
            op       = OP_R_PV;
            state_in = flags.h_gt ? S_R_PVF : S_R_PUSH;
         end
         S_R_PVF: begin
            op       = OP_R_PVF;
            state_in = flags.pv_ge ? S_R_PVH : S_R_PUSH;
         end
         S_R_PVH: begin
            op = OP_R_PVH;
            if (!flags.rd_used) begin
               state_in = S_U0;
               ret_in   = S_R_PVM;
            end else begin
               state_in = S_R_PUSH;
            end
         end
         S_R_PVM: begin
            op       = OP_R_PVM;
            state_in = S_T0;
            ret_in   = S_R_PUSH;
         end
         S_R_PUSH: begin
            op       = OP_R_PUSH;
            state_in = S_P0;
            ret_in   = S_DONE;
         end
         S_T0: begin
            op       = OP_T0;
            state_in = S_T1;
         end
         S_T1: begin
            op       = OP_T1;
            state_in = ret_ff;
         end
         S_P0: begin
            op       = OP_P0;
            state_in = S_P1;
         end
         S_P1: begin
            op       = OP_P1;
            state_in = S_P2;
         end
         S_P2: begin
            op       = OP_P2;
            state_in = ret_ff;
         end
         S_U0: begin
            op       = OP_U0;
            state_in = S_U1;
         end
         S_U1: begin
            op       = OP_U1;
            state_in = S_U2;
         end
         S_U2: begin
            op       = OP_U2;
            state_in = S_U3;
         end
         S_U3: begin
            op       = OP_U3;
            state_in = S_U4;
         end
         S_U4: begin
            op       = OP_U4;
            state_in = S_U5;
         end
         S_U5: begin
            op       = OP_U5;
            state_in = ret_ff;
         end
         S_DONE: begin
            if (flags.out_free) begin
               op       = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

### rtl/core/btha_dp.sv
// Datapath of the allocator: heap memory, pointers, sizes and result register.
`timescale 1ns / 1ps
module btha_dp #(
   parameter int HEAP_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  btha_pkg::op_type    op,
   input  btha_pkg::req_type   req_data,
   input  logic [31:0]         region_start,
   input  logic [16:0]         region_bytes,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output btha_pkg::rsp_type   rsp_data,
   output btha_pkg::flags_type flags
);
   import btha_pkg::*;

   localparam int HEAP_WORDS = HEAP_BYTES / 8;
   localparam int IDX_W      = $clog2(HEAP_WORDS);
   localparam int SIZE_W     = ($clog2(HEAP_BYTES) + 2 > 18) ? $clog2(HEAP_BYTES) + 2 : 18;
   localparam int CAP_BYTES  = (HEAP_BYTES / GRANULE_BYTES) * GRANULE_BYTES;
   localparam int AW         = ADDR_W;

   localparam logic [AW-1:0]     A_HDR  = AW'(HDR_BYTES);
   localparam logic [AW-1:0]     A_FTR  = AW'(FTR_BYTES);
   localparam logic [AW-1:0]     A_MIN  = AW'(MIN_BLOCK);
   localparam logic [AW-1:0]     A_GMSK = AW'(GRANULE_BYTES - 1);
   localparam logic [SIZE_W-1:0] S_GMSK = SIZE_W'(GRANULE_BYTES - 1);
   localparam logic [SIZE_W-1:0] S_MIN  = SIZE_W'(MIN_BLOCK);
   localparam logic [SIZE_W-1:0] S_CAP  = SIZE_W'(CAP_BYTES);

   logic [63:0] mem_q [HEAP_WORDS];
   logic [63:0] rd_ff;

   logic [AW-1:0] hb_ff, hb_in, he_ff, he_in, head_ff, head_in;
   logic          fmt_ff, fmt_in;
   logic [SIZE_W-1:0] ft_ff, ft_in;

   logic [1:0]  cmd_ff, cmd_in;
   logic [16:0] req_bytes_ff, req_bytes_in;
   logic [16:0] align_raw_ff, align_raw_in;
   logic [16:0] align_ff, align_in;
   logic [31:0] addr_ff, addr_in;
   logic [SIZE_W-1:0] need_ff, need_in;

   logic [AW-1:0] node_ff, node_in, bb_ff, bb_in, be_ff, be_in, ah_ff, ah_in;
   logic [AW-1:0] h_ff, h_in, pv_ff, pv_in, un_ff, un_in, push_ff, push_in;
   logic [AW-1:0] tag_h_ff, tag_h_in, lnk_nx_ff, lnk_nx_in, lnk_pv_ff, lnk_pv_in;
   logic [SIZE_W-1:0] fsz_ff, fsz_in, sz_ff, sz_in, nsz_ff, nsz_in;
   logic [SIZE_W-1:0] tag_sz_ff, tag_sz_in;
   logic              tag_used_ff, tag_used_in;
   logic [31:0]       grant_ff, grant_in;
   logic [2:0]        status_ff, status_in;

   rsp_type out_ff, out_in;
   logic    out_v_ff, out_v_in;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr, mem_off;
   logic [63:0]   mem_wd;
   logic [IDX_W-1:0] mem_idx;

   // Values derived from registers and the last memory read.
   logic [SIZE_W-1:0] rd_size;
   logic [AW-1:0]     rd_ptr, ah_need, suffix, pfx, pv_calc, ah_start, a_mask, span;
   logic [63:0]       tag_word;

   // Format arithmetic.
   logic [AW-1:0]     f_b, f_ab, f_diff;
   logic              f_small;
   logic [16:0]       f_n1;
   logic [SIZE_W-1:0] f_n2, f_n3;
   logic              f_ok;

   // Allocate argument checks.
   logic [16:0] a_eff;
   logic        a_pow2;
   logic [17:0] r_round, r_need;

   assign rd_size  = rd_ff[SIZE_W-1:0] & ~S_GMSK;
   assign rd_ptr   = rd_ff[AW-1:0];
   assign ah_need  = ah_ff + AW'(need_ff);
   assign suffix   = be_ff - ah_need;
   assign pfx      = ah_ff - bb_ff;
   assign pv_calc  = h_ff - AW'(rd_size);
   assign a_mask   = AW'(align_ff) - AW'(1);
   assign ah_start = ((bb_ff + A_HDR + a_mask) & ~a_mask) - A_HDR;
   assign span     = he_ff - hb_ff;
   assign tag_word = 64'(tag_sz_ff) | 64'(tag_used_ff);

   always_comb begin
      f_b     = AW'(region_start);
      f_ab    = (f_b + A_GMSK) & ~A_GMSK;
      f_diff  = f_ab - f_b;
      f_small = (f_diff != '0) && (region_bytes <= 17'(f_diff[3:0]));
      f_n1    = region_bytes - 17'(f_diff[3:0]);
      f_n2    = SIZE_W'(f_n1) & ~S_GMSK;
      f_n3    = (f_n2 > S_CAP) ? S_CAP : f_n2;
      f_ok    = !f_small && (f_n3 >= S_MIN);
   end

   always_comb begin
      a_eff   = (align_raw_ff < 17'(GRANULE_BYTES)) ? 17'(GRANULE_BYTES) : align_raw_ff;
      a_pow2  = ((a_eff & (a_eff - 17'd1)) == '0);
      r_round = (18'(req_bytes_ff) + 18'(GRANULE_BYTES - 1)) & ~18'(GRANULE_BYTES - 1);
      r_need  = r_round + 18'(HDR_BYTES + HDR_BYTES);
      if (r_need < 18'(MIN_BLOCK)) r_need = 18'(MIN_BLOCK);
   end

   always_comb begin
      flags.cmd = cmd_ff;
      unique case (cmd_ff)
         CMD_FORMAT:  flags.disp_ok = f_ok;
         CMD_ALLOC:   flags.disp_ok = fmt_ff && a_pow2;
         CMD_RELEASE: flags.disp_ok = fmt_ff && (addr_ff != '0);
         default:     flags.disp_ok = 1'b0;
      endcase
      flags.out_free  = !out_v_ff || !rsp_stall;
      flags.node_zero = (node_ff == '0);
      flags.bump      = (ah_ff > bb_ff) && (pfx < A_MIN);
      flags.fits      = (ah_need <= be_ff);
      flags.pfx_big   = (pfx >= A_MIN);
      flags.suf_big   = (suffix >= A_MIN);
      flags.suf_nz    = (suffix != '0);
      flags.h_end     = (h_ff >= he_ff);
      flags.found     = ((h_ff + A_HDR) & AW'(32'hFFFF_FFFF)) == AW'(addr_ff) && rd_ff[0];
      flags.s_zero    = (rd_size == '0);
      flags.nx_in     = ((h_ff + AW'(sz_ff)) < he_ff);
      flags.rd_used   = rd_ff[0];
      flags.h_gt      = (h_ff > hb_ff);
      flags.pv_ge     = (pv_calc >= hb_ff);
   end

   always_comb begin
      hb_in = hb_ff;  he_in = he_ff;  head_in = head_ff;  fmt_in = fmt_ff;  ft_in = ft_ff;
      cmd_in = cmd_ff;  req_bytes_in = req_bytes_ff;  align_raw_in = align_raw_ff;
      align_in = align_ff;  addr_in = addr_ff;  need_in = need_ff;
      node_in = node_ff;  bb_in = bb_ff;  be_in = be_ff;  ah_in = ah_ff;
      h_in = h_ff;  pv_in = pv_ff;  un_in = un_ff;  push_in = push_ff;
      tag_h_in = tag_h_ff;  lnk_nx_in = lnk_nx_ff;  lnk_pv_in = lnk_pv_ff;
      fsz_in = fsz_ff;  sz_in = sz_ff;  nsz_in = nsz_ff;
      tag_sz_in = tag_sz_ff;  tag_used_in = tag_used_ff;
      grant_in = grant_ff;  status_in = status_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && rsp_stall;
      mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = hb_ff;  mem_wd = '0;

      unique case (op)
         OP_NONE: ;
         OP_LATCH: begin
            cmd_in       = req_data.cmd;
            req_bytes_in = req_data.request_bytes;
            align_raw_in = req_data.align_bytes;
            addr_in      = req_data.release_addr;
         end
         OP_DISPATCH: begin
            grant_in = '0;
            unique case (cmd_ff)
               CMD_FORMAT: begin
                  if (f_ok) begin
                     hb_in       = f_ab;
                     he_in       = f_ab + AW'(f_n3);
                     head_in     = f_ab + A_HDR;
                     fmt_in      = 1'b1;
                     ft_in       = f_n3;
                     tag_h_in    = f_ab;
                     tag_sz_in   = f_n3;
                     tag_used_in = 1'b0;
                     status_in   = ST_OK;
                  end else begin
                     hb_in     = '0;
                     he_in     = '0;
                     head_in   = '0;
                     fmt_in    = 1'b0;
                     ft_in     = '0;
                     status_in = ST_TOO_SMALL;
                  end
               end
               CMD_ALLOC: begin
                  align_in = a_eff;
                  need_in  = SIZE_W'(r_need);
                  node_in  = head_ff;
                  priority if (!fmt_ff) status_in = ST_NOT_FMT;
                  else if (!a_pow2)     status_in = ST_BAD_ALIGN;
                  else                  status_in = ST_NO_FIT;
               end
               CMD_RELEASE: begin
                  h_in = hb_ff;
                  priority if (!fmt_ff) status_in = ST_NOT_FMT;
                  else                  status_in = ST_IGNORED;
               end
               default: status_in = ST_IGNORED;
            endcase
         end
         OP_FMT_NXT: begin
            mem_we   = 1'b1;
            mem_addr = hb_ff + A_HDR;
         end
         OP_FMT_PRV: begin
            mem_we   = 1'b1;
            mem_addr = hb_ff + A_HDR + A_FTR;
         end
         OP_A_LOOP: begin
            if (node_ff != '0) begin
               mem_re   = 1'b1;
               mem_addr = node_ff - A_HDR;
               bb_in    = node_ff - A_HDR;
            end
         end
         OP_A_HDR: begin
            fsz_in = rd_size;
            be_in  = bb_ff + AW'(rd_size);
            ah_in  = ah_start;
         end
         OP_A_BUMP: begin
            if (flags.bump) ah_in = ah_ff + AW'(align_ff);
         end
         OP_A_FIT: begin
            if (flags.fits) begin
               un_in = node_ff;
               ft_in = ft_ff - fsz_ff;
            end else begin
               mem_re   = 1'b1;
               mem_addr = node_ff;
            end
         end
         OP_A_NEXT: node_in = rd_ptr;
         OP_A_PFX: begin
            if (flags.pfx_big) begin
               tag_h_in    = bb_ff;
               tag_sz_in   = pfx[SIZE_W-1:0];
               tag_used_in = 1'b0;
               ft_in       = ft_ff + pfx[SIZE_W-1:0];
            end
         end
         OP_A_PPUSH: push_in = bb_ff + A_HDR;
         OP_A_USED: begin
            tag_h_in    = ah_ff;
            tag_sz_in   = need_ff;
            tag_used_in = 1'b1;
         end
         OP_A_SUF: begin
            grant_in  = 32'(ah_ff + A_HDR);
            status_in = ST_OK;
            priority if (flags.suf_big) begin
               tag_h_in    = ah_need;
               tag_sz_in   = suffix[SIZE_W-1:0];
               tag_used_in = 1'b0;
               ft_in       = ft_ff + suffix[SIZE_W-1:0];
            end else if (flags.suf_nz) begin
               // A leftover too small to stand alone stays with the grant.
               tag_h_in    = ah_ff;
               tag_sz_in   = need_ff + suffix[SIZE_W-1:0];
               tag_used_in = 1'b1;
            end else begin
               tag_h_in = tag_h_ff;
            end
         end
         OP_A_SPUSH: push_in = ah_need + A_HDR;
         OP_R_WALK: begin
            if (!flags.h_end) begin
               mem_re   = 1'b1;
               mem_addr = h_ff;
            end
         end
         OP_R_WHDR: begin
            priority if (flags.found) sz_in = rd_size;
            else if (!flags.s_zero)   h_in  = h_ff + AW'(rd_size);
            else                      h_in  = h_ff;
         end
         OP_R_FOUND: begin
            ft_in       = ft_ff + sz_ff;
            tag_h_in    = h_ff;
            tag_sz_in   = sz_ff;
            tag_used_in = 1'b0;
            status_in   = ST_OK;
         end
         OP_R_NX: begin
            if (flags.nx_in) begin
               mem_re   = 1'b1;
               mem_addr = h_ff + AW'(sz_ff);
            end
         end
         OP_R_NXH: begin
            if (!flags.rd_used) begin
               nsz_in = rd_size;
               un_in  = h_ff + AW'(sz_ff) + A_HDR;
            end
         end
         OP_R_NXM: begin
            sz_in       = sz_ff + nsz_ff;
            tag_h_in    = h_ff;
            tag_sz_in   = sz_ff + nsz_ff;
            tag_used_in = 1'b0;
         end
         OP_R_PV: begin
            if (flags.h_gt) begin
               mem_re   = 1'b1;
               mem_addr = h_ff - A_FTR;
            end
         end
         OP_R_PVF: begin
            pv_in = pv_calc;
            if (flags.pv_ge) begin
               mem_re   = 1'b1;
               mem_addr = pv_calc;
            end
         end
         OP_R_PVH: begin
            if (!flags.rd_used) begin
               nsz_in = rd_size;
               un_in  = pv_ff + A_HDR;
            end
         end
         OP_R_PVM: begin
            sz_in       = nsz_ff + sz_ff;
            h_in        = pv_ff;
            tag_h_in    = pv_ff;
            tag_sz_in   = nsz_ff + sz_ff;
            tag_used_in = 1'b0;
         end
         OP_R_PUSH: push_in = h_ff + A_HDR;
         OP_T0: begin
            mem_we   = 1'b1;
            mem_addr = tag_h_ff;
            mem_wd   = tag_word;
         end
         OP_T1: begin
            mem_we   = 1'b1;
            mem_addr = tag_h_ff + AW'(tag_sz_ff) - A_FTR;
            mem_wd   = tag_word;
         end
         OP_P0: begin
            mem_we   = 1'b1;
            mem_addr = push_ff + A_FTR;
         end
         OP_P1: begin
            mem_we   = 1'b1;
            mem_addr = push_ff;
            mem_wd   = 64'(head_ff);
         end
         OP_P2: begin
            if (head_ff != '0) begin
               mem_we   = 1'b1;
               mem_addr = head_ff + A_FTR;
               mem_wd   = 64'(push_ff);
            end
            head_in = push_ff;
         end
         OP_U0: begin
            mem_re   = 1'b1;
            mem_addr = un_ff;
         end
         OP_U1: begin
            lnk_nx_in = rd_ptr;
            mem_re    = 1'b1;
            mem_addr  = un_ff + A_FTR;
         end
         OP_U2: begin
            lnk_pv_in = rd_ptr;
            if (rd_ptr != '0) begin
               mem_we   = 1'b1;
               mem_addr = rd_ptr;
               mem_wd   = 64'(lnk_nx_ff);
            end else begin
               head_in = lnk_nx_ff;
            end
         end
         OP_U3: begin
            if (lnk_nx_ff != '0) begin
               mem_we   = 1'b1;
               mem_addr = lnk_nx_ff + A_FTR;
               mem_wd   = 64'(lnk_pv_ff);
            end
         end
         OP_U4: begin
            mem_we   = 1'b1;
            mem_addr = un_ff;
         end
         OP_U5: begin
            mem_we   = 1'b1;
            mem_addr = un_ff + A_FTR;
         end
         OP_EMIT: begin
            out_v_in            = 1'b1;
            out_in.payload_addr = grant_ff;
            out_in.status       = status_ff;
            out_in.free_total   = fmt_ff ? ft_ff[16:0] : '0;
            out_in.heap_total   = fmt_ff ? span[16:0] : '0;
         end
         default: ;
      endcase
   end

   // Word index is the offset from the heap base, wrapped to the memory depth.
   assign mem_off = mem_addr - hb_ff;
   assign mem_idx = mem_off[IDX_W+2:3];

   always_ff @(posedge clock) begin
      if (mem_we) mem_q[mem_idx] <= mem_wd;
      if (mem_re) rd_ff <= mem_q[mem_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_ff    <= '0;
         he_ff    <= '0;
         head_ff  <= '0;
         fmt_ff   <= 1'b0;
         ft_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         hb_ff    <= hb_in;
         he_ff    <= he_in;
         head_ff  <= head_in;
         fmt_ff   <= fmt_in;
         ft_ff    <= ft_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      req_bytes_ff <= req_bytes_in;
      align_raw_ff <= align_raw_in;
      align_ff     <= align_in;
      addr_ff      <= addr_in;
      need_ff      <= need_in;
      node_ff      <= node_in;
      bb_ff        <= bb_in;
      be_ff        <= be_in;
      ah_ff        <= ah_in;
      h_ff         <= h_in;
      pv_ff        <= pv_in;
      un_ff        <= un_in;
      push_ff      <= push_in;
      tag_h_ff     <= tag_h_in;
      lnk_nx_ff    <= lnk_nx_in;
      lnk_pv_ff    <= lnk_pv_in;
      fsz_ff       <= fsz_in;
      sz_ff        <= sz_in;
      nsz_ff       <= nsz_in;
      tag_sz_ff    <= tag_sz_in;
      tag_used_ff  <= tag_used_in;
      grant_ff     <= grant_in;
      status_ff    <= status_in;
      out_ff       <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

### tb/sv/tb_boundary_tag_heap_allocator.sv
// Self-checking testbench of the boundary-tag heap allocator with a heap predictor.
`timescale 1ns / 1ps
module tb_boundary_tag_heap_allocator;
   import btha_pkg::*;

   localparam int HEAP_BYTES  = 65536;
   localparam int HEAP_DEPTH  = HEAP_BYTES / 8;
   localparam int IDLE_LIMIT  = 60000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 150;
   localparam logic [2:0] REG_START = 3'd0;
   localparam logic [2:0] REG_BYTES = 3'd4;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   typedef enum { ROW_CMD, ROW_SET_START, ROW_SET_BYTES } row_kind_type;
   typedef struct {
      row_kind_type kind;
      logic [31:0]  val;
      req_type      rq;
      bit           typed;
      rsp_type      ex;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) i_dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Predictor state: a copy of the heap memory and the allocator registers.
   logic [63:0]     heap_mem [HEAP_DEPTH];
   longint unsigned heap_lo, heap_hi, free_head;
   bit              is_formatted;
   int unsigned     free_sum;
   logic [31:0]     region_start_q, region_bytes_q;

   rsp_type     pending_rsp[$];
   int unsigned live_grants[$];
   int          errors;
   int          idle_cycles;
   bit          quiet;

   function automatic logic [12:0] word_at(longint unsigned a);
      longint unsigned off;
      off = (a - heap_lo) >> 3;
      return off[12:0];
   endfunction

   function automatic longint unsigned mem_rd(longint unsigned a);
      return heap_mem[word_at(a)];
   endfunction

   function automatic void mem_wr(longint unsigned a, longint unsigned v);
      heap_mem[word_at(a)] = v;
   endfunction

   function automatic longint unsigned tag_size(longint unsigned h);
      return mem_rd(h) & ~64'hF;
   endfunction

   function automatic bit tag_used(longint unsigned h);
      return mem_rd(h) & 64'h1;
   endfunction

   function automatic void write_tags(longint unsigned h, longint unsigned sz, bit used);
      mem_wr(h, sz | longint'(used));
      mem_wr(h + sz - FTR_BYTES, sz | longint'(used));
   endfunction

   function automatic void free_list_unlink(longint unsigned node);
      longint unsigned nx, pv;
      nx = mem_rd(node);
      pv = mem_rd(node + 8);
      if (pv != 0) mem_wr(pv, nx);
      else free_head = nx;
      if (nx != 0) mem_wr(nx + 8, pv);
      mem_wr(node, 0);
      mem_wr(node + 8, 0);
   endfunction

   function automatic void free_list_push(longint unsigned node);
      mem_wr(node + 8, 0);
      mem_wr(node, free_head);
      if (free_head != 0) mem_wr(free_head + 8, node);
      free_head = node;
   endfunction

   function automatic void heap_clear();
      is_formatted = 0;
      heap_lo = 0;
      heap_hi = 0;
      free_head = 0;
      free_sum = 0;
   endfunction

   function automatic logic [2:0] heap_format();
      longint unsigned b, ab, n;
      b = region_start_q;
      ab = (b + 15) & ~64'hF;
      n = region_bytes_q;
      if (ab > b) begin
         if (n <= ab - b) begin
            heap_clear();
            return ST_TOO_SMALL;
         end
         n -= ab - b;
      end
      n &= ~64'hF;
      if (n > HEAP_BYTES) n = HEAP_BYTES;
      if (n < MIN_BLOCK) begin
         heap_clear();
         return ST_TOO_SMALL;
      end
      heap_lo = ab;
      heap_hi = ab + n;
      write_tags(ab, n, 0);
      mem_wr(ab + HDR_BYTES, 0);
      mem_wr(ab + HDR_BYTES + 8, 0);
      free_head = ab + HDR_BYTES;
      is_formatted = 1;
      free_sum = n;
      return ST_OK;
   endfunction

   function automatic logic [2:0] heap_allocate(longint unsigned want, longint unsigned al,
                                                output longint unsigned grant);
      longint unsigned need, node, bb, fsz, be, ah, prefix, sb, suffix;
      int g;
      grant = 0;
      if (!is_formatted) return ST_NOT_FMT;
      if (al < 16) al = 16;
      if ((al & (al - 1)) != 0) return ST_BAD_ALIGN;
      need = ((want + 15) & ~64'hF) + HDR_BYTES + FTR_BYTES;
      need = (need + 15) & ~64'hF;
      if (need < MIN_BLOCK) need = MIN_BLOCK;
      node = free_head;
      for (g = 0; node != 0 && g <= HEAP_DEPTH; g++) begin
         bb = node - HDR_BYTES;
         fsz = tag_size(bb);
         be = bb + fsz;
         ah = ((bb + HDR_BYTES + al - 1) & ~(al - 1)) - HDR_BYTES;
         // A prefix under the minimum block cannot stand alone, so move up.
         while (ah > bb && ah - bb < MIN_BLOCK) begin
            ah += al;
            if (ah + need > be) break;
         end
         if (ah + need > be) begin
            node = mem_rd(node);
            continue;
         end
         prefix = ah - bb;
         free_list_unlink(node);
         free_sum -= fsz;
         if (prefix >= MIN_BLOCK) begin
            write_tags(bb, prefix, 0);
            free_list_push(bb + HDR_BYTES);
            free_sum += prefix;
         end
         write_tags(ah, need, 1);
         sb = ah + need;
         suffix = be - sb;
         if (suffix >= MIN_BLOCK) begin
            write_tags(sb, suffix, 0);
            free_list_push(sb + HDR_BYTES);
            free_sum += suffix;
         end else if (suffix != 0) begin
            write_tags(ah, need + suffix, 1);
         end
         grant = ah + HDR_BYTES;
         return ST_OK;
      end
      return ST_NO_FIT;
   endfunction

   function automatic logic [2:0] heap_release(longint unsigned addr);
      longint unsigned h, s, nx, pv, sz;
      bit hit;
      int g;
      if (!is_formatted) return ST_NOT_FMT;
      if (addr == 0) return ST_IGNORED;
      hit = 0;
      h = heap_lo;
      for (g = 0; h < heap_hi && g <= HEAP_DEPTH; g++) begin
         s = tag_size(h);
         if (((h + HDR_BYTES) & 64'hFFFF_FFFF) == addr && tag_used(h)) begin
            hit = 1;
            break;
         end
         if (s == 0) break;
         h += s;
      end
      if (!hit) return ST_IGNORED;
      sz = tag_size(h);
      free_sum += sz;
      write_tags(h, sz, 0);
      nx = h + sz;
      if (nx < heap_hi && !tag_used(nx)) begin
         free_list_unlink(nx + HDR_BYTES);
         write_tags(h, tag_size(h) + tag_size(nx), 0);
      end
      if (h > heap_lo) begin
         pv = h - (mem_rd(h - FTR_BYTES) & ~64'hF);
         if (pv >= heap_lo && !tag_used(pv)) begin
            free_list_unlink(pv + HDR_BYTES);
            write_tags(pv, tag_size(pv) + tag_size(h), 0);
            h = pv;
         end
      end
      free_list_push(h + HDR_BYTES);
      return ST_OK;
   endfunction

   // Works out the result of one command and keeps the list of live grants.
   function automatic rsp_type heap_predict(req_type r);
      rsp_type o;
      longint unsigned grant;
      longint unsigned span;
      grant = 0;
      case (r.cmd)
         CMD_FORMAT: begin
            o.status = heap_format();
            live_grants.delete();
         end
         CMD_ALLOC: begin
            o.status = heap_allocate(r.request_bytes, r.align_bytes, grant);
            if (o.status == ST_OK) live_grants.push_back(grant[31:0]);
         end
         CMD_RELEASE: begin
            o.status = heap_release(r.release_addr);
            if (o.status == ST_OK)
               foreach (live_grants[i])
                  if (live_grants[i] == r.release_addr) begin
                     live_grants.delete(i);
                     break;
                  end
         end
         default: o.status = ST_IGNORED;
      endcase
      span = heap_hi - heap_lo;
      o.payload_addr = grant[31:0];
      o.free_total = is_formatted ? free_sum[16:0] : 17'd0;
      o.heap_total = is_formatted ? span[16:0] : 17'd0;
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Valid stays up after the accepting edge until the next beat or an idle stretch.
   task automatic send_beat(req_type r, bit typed, rsp_type ex);
      rsp_type p;
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      p = heap_predict(r);
      pending_rsp.push_back(typed ? ex : p);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == REG_START) region_start_q = val;
      else region_bytes_q = val & 32'h1_FFFF;
      @(posedge clock);
   endtask

   function automatic req_type random_req();
      req_type r;
      int pick;
      int k;
      r.cmd = CMD_ALLOC;
      r.request_bytes = $urandom_range(0, 200);
      r.align_bytes = 0;
      r.release_addr = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 19) == 0) r.request_bytes = $urandom_range(0, 17'h1FFFF);
         k = $urandom_range(0, 9);
         if (k < 6) r.align_bytes = 17'd1 << $urandom_range(0, 16);
         else if (k == 6) r.align_bytes = $urandom_range(0, 17'h1FFFF);
      end else if (pick < 85) begin
         r.cmd = CMD_RELEASE;
         if (live_grants.size() != 0)
            r.release_addr = live_grants[$urandom_range(0, live_grants.size() - 1)];
      end else if (pick < 95) begin
         r.cmd = CMD_RELEASE;
         if (live_grants.size() != 0 && pick < 90)
            r.release_addr = live_grants[0] + 16;
      end else if (pick < 98) begin
         r.cmd = CMD_NONE;
      end else begin
         r.cmd = CMD_FORMAT;
      end
      return r;
   endfunction

   dir_row_type dir_tab[] = '{
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd64, 17'd0, 32'd0}, 1, '{32'd0, ST_NOT_FMT, 17'd0, 17'd0}},
      '{ROW_CMD, 0, '{CMD_RELEASE, 17'd0, 17'd0, 32'h1010}, 1,
        '{32'd0, ST_NOT_FMT, 17'd0, 17'd0}},
      '{ROW_CMD, 0, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 1, '{32'd0, ST_IGNORED, 17'd0, 17'd0}},
      '{ROW_CMD, 0, '{CMD_FORMAT, 17'd0, 17'd0, 32'd0}, 1,
        '{32'd0, ST_TOO_SMALL, 17'd0, 17'd0}},
      '{ROW_SET_START, 32'h1003, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_SET_BYTES, 32'h1FFFF, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_FORMAT, 17'd0, 17'd0, 32'd0}, 1,
        '{32'd0, ST_OK, 17'h10000, 17'h10000}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd0, 17'd0, 32'd0}, 1,
        '{32'h1020, ST_OK, 17'd65488, 17'h10000}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'h1FFFF, 17'd16, 32'd0}, 1,
        '{32'd0, ST_NO_FIT, 17'd65488, 17'h10000}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd32, 17'd24, 32'd0}, 1,
        '{32'd0, ST_BAD_ALIGN, 17'd65488, 17'h10000}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd32, 17'h1FFFF, 32'd0}, 1,
        '{32'd0, ST_BAD_ALIGN, 17'd65488, 17'h10000}},
      '{ROW_CMD, 0, '{CMD_RELEASE, 17'd0, 17'd0, 32'd0}, 1,
        '{32'd0, ST_IGNORED, 17'd65488, 17'h10000}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd100, 17'h10000, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_RELEASE, 17'd0, 17'd0, 32'h1020}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_RELEASE, 17'd0, 17'd0, 32'h1020}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_RELEASE, 17'd0, 17'd0, 32'hFFFFFFFF}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'h10000, 17'd32, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_NONE, 17'h1FFFF, 17'h1FFFF, 32'hFFFFFFFF}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_SET_START, 32'hFFFFFFF8, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_SET_BYTES, 32'd100, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_FORMAT, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd16, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_SET_START, 32'h11, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_SET_BYTES, 32'd15, '{CMD_NONE, 17'd0, 17'd0, 32'd0}, 0, '{32'd0, 3'd0, 0, 0}},
      '{ROW_CMD, 0, '{CMD_FORMAT, 17'd0, 17'd0, 32'd0}, 1,
        '{32'd0, ST_TOO_SMALL, 17'd0, 17'd0}},
      '{ROW_CMD, 0, '{CMD_ALLOC, 17'd16, 17'd0, 32'd0}, 1, '{32'd0, ST_NOT_FMT, 17'd0, 17'd0}}
   };

   // Result side: random stall before each beat, none in quiet stretches.
   initial begin
      int w;
      rsp_stall <= 1'b1;
      @(negedge reset);
      forever begin
         w = quiet ? 0 : $urandom_range(0, 9);
         repeat (w) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      rsp_type ex;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected result beat, payload_addr", rsp_data.payload_addr, 0);
         end else begin
            ex = pending_rsp.pop_front();
            if (rsp_data.payload_addr !== ex.payload_addr)
               report("payload_addr", rsp_data.payload_addr, ex.payload_addr);
            if (rsp_data.status !== ex.status)
               report("status", rsp_data.status, ex.status);
            if (rsp_data.free_total !== ex.free_total)
               report("free_total", rsp_data.free_total, ex.free_total);
            if (rsp_data.heap_total !== ex.heap_total)
               report("heap_total", rsp_data.heap_total, ex.heap_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("boundary_tag_heap_allocator: mismatch");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      logic [31:0] st, nb;
      errors = 0;
      quiet = 0;
      heap_clear();
      region_start_q = 0;
      region_bytes_q = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CMD) begin
            send_beat(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].ex);
         end else begin
            wait_quiet();
            csr_write(dir_tab[i].kind == ROW_SET_START ? REG_START : REG_BYTES,
                      dir_tab[i].val);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         // Registers change only once every result of the last phase is in.
         wait_quiet();
         quiet = (ph % 4 == 3);
         st = $urandom;
         nb = 17'h10000;
         case (ph % 6)
            0: st[3:0] = 4'd0;
            1: nb = 17'h1FFFF;
            2: begin
               st = 32'hFFFFFFFF - $urandom_range(0, 64);
               nb = $urandom_range(48, 17'h1FFFF);
            end
            3: nb = $urandom_range(48, 400);
            4: nb = $urandom_range(0, 60);
            default: nb = $urandom_range(200, 4096);
         endcase
         csr_write(REG_START, st);
         csr_write(REG_BYTES, nb);
         r = '{CMD_FORMAT, 17'd0, 17'd0, 32'd0};
         send_beat(r, 0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) send_beat(random_req(), 0, '0);
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("boundary_tag_heap_allocator: match");
      else $display("boundary_tag_heap_allocator: mismatch");
      $finish;
   end

endmodule
